// ===== sv/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, codes and constants of the annealing swap engine.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int COST_W = 22;
  localparam int CITY_W = 6;

  localparam logic [COST_W-1:0] COST_MAX = 22'h3FFFFF;
  localparam logic [30:0]       Q30_ONE  = 31'h4000_0000;

  localparam logic [3:0] SERIES_TERMS = 4'd12;
  localparam logic [3:0] EXP_K_LIMIT  = 4'd12;
  localparam logic [5:0] DIV_STEPS    = 6'd54;

  localparam logic [6:0]  NUM_CITIES_RST = 7'd64;
  localparam logic [31:0] INIT_TEMP_RST  = 32'd65536000;
  localparam logic [15:0] COOL_RST       = 16'd64880;
  localparam logic [15:0] FREEZE_RST     = 16'd7;

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_RESET   = 3'd1,
    CMD_FORCE   = 3'd2,
    CMD_PROPOSE = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FROZEN  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_NUM_CITIES = 2'd0,
    CFG_INIT_TEMP  = 2'd1,
    CFG_COOL_RATE  = 2'd2,
    CFG_FREEZE     = 2'd3
  } cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_EVAL,
    ST_DIV,
    ST_XCHK,
    ST_SER_MUL,
    ST_SER_DIV,
    ST_SER_FIX,
    ST_POW,
    ST_PMUL,
    ST_PFIN,
    ST_WR_A,
    ST_WR_B,
    ST_COPY,
    ST_RDB,
    ST_DONE
  } state_e;

  // floor(2^32 / i), the first entry one short so it fits 32 bits
  function automatic logic [31:0] recip(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd1:    r = 32'hFFFF_FFFF;
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/tsp_ram.sv =====
// ----------------------------------------------------------------------------
// tsp_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tsp_annealing_swap_engine_core.sv =====
// ----------------------------------------------------------------------------
// tsp_annealing_swap_engine_core
// Simulated annealing on a closed tour by two-city swaps: distance matrix,
// current and best tour held in RAM, exp acceptance in fixed point.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, cmd, pos_a, pos_b,       | input
//          | distance, rand_u                                |
//  out     | out_valid_o/out_ready_i, current_cost, best_cost| output
//          | accepted, frozen, best_city, status             |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i| input
//
// one item at a time. load and refused items go from decode to done, a
// read through ST_RDB. a cost walk reads one tour entry per cycle through
// the tour RAM read port and the distance RAM. a rising cost adds a
// restoring division, two 12-term exp series of multiply, divide and fix
// states a term, the power steps and the final compare. an accepted swap
// writes back in ST_WR_A, ST_WR_B; a new best tour copies all MAX_CITIES.
// after reset the tours read as identity at once, no clearing pass.
// the output register frees the engine while a result waits downstream.
module tsp_annealing_swap_engine_core
  import tsp_pkg::*;
#(
  parameter int MAX_CITIES   = 64,
  parameter int DIST_BITS    = 16,
  parameter int ROUND_FACTOR = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        cmd_i,
  input  logic [5:0]        pos_a_i,
  input  logic [5:0]        pos_b_i,
  input  logic [15:0]       distance_i,
  input  logic [15:0]       rand_u_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [21:0]       current_cost_o,
  output logic [21:0]       best_cost_o,
  output logic              accepted_o,
  output logic              frozen_o,
  output logic [5:0]        best_city_o,
  output logic [1:0]        status_o
);

  localparam int CW  = $clog2(MAX_CITIES);
  localparam int NW  = ($clog2(MAX_CITIES + 1) > 7) ? $clog2(MAX_CITIES + 1) : 7;
  localparam int PCW = $clog2(ROUND_FACTOR * MAX_CITIES + 1);
  localparam int DAW = 2 * CW;
  localparam int AW  = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;

  state_e state_q, state_d;

  // configuration
  logic [6:0]  num_cities_q;
  logic [31:0] init_temp_q;
  logic [15:0] cool_q;
  logic [15:0] freeze_q;

  // engine state
  logic [MAX_CITIES-1:0] cur_vld_q, best_vld_q;
  logic [COST_W-1:0]     cur_cost_q, best_cost_q;
  logic [31:0]           temp_q;
  logic [PCW-1:0]        pcount_q;

  // captured item
  logic [2:0]  cmd_q;
  logic [5:0]  pa_q, pb_q;
  logic [15:0] dist_q;
  logic [15:0] u_q;

  // walk pipeline
  logic [NW-1:0]     iss_q;
  logic              swp_q;
  logic              a_vld_q, a_vbit_q, a_first_q, a_last_q, a_isa_q, a_isb_q;
  logic [CW-1:0]     a_addr_q;
  logic [CW-1:0]     prev_q, first_q, new_a_q, new_b_q;
  logic              close_q, d_vld_q, d_end_q;
  logic [COST_W-1:0] acc_q;

  // divider and exp
  logic [32:0] rem_q;
  logic [53:0] dd_q;
  logic [19:0] xq_q;
  logic        big_q;
  logic [5:0]  div_cnt_q;
  logic [30:0] t_q, s_q, e1_q, ek_q, ef_q;
  logic [61:0] prod_q, pprod_q;
  logic [30:0] y_q;
  logic [62:0] yq_q;
  logic [3:0]  i_q, pow_cnt_q;
  logic        phase_q;

  // commit, copy, read
  logic          best_upd_q;
  logic [NW-1:0] cp_iss_q;
  logic          cp_vld_q, cp_vbit_q;
  logic [CW-1:0] cp_addr_q;
  logic          rb_vbit_q;
  logic [CW-1:0] rb_addr_q;

  // result
  logic              res_acc_q;
  logic [CITY_W-1:0] res_city_q;
  logic [1:0]        res_status_q;
  logic              out_valid_q;
  logic [COST_W-1:0] out_cur_q, out_best_q;
  logic              out_acc_q, out_frz_q;
  logic [CITY_W-1:0] out_city_q;
  logic [1:0]        out_status_q;

  // RAM ports
  logic [DIST_BITS-1:0] dist_rdata;
  logic [DAW-1:0]       dist_raddr;
  logic                 dist_we;
  logic [CW-1:0]        cur_rdata, best_rdata, cur_raddr, cur_waddr, cur_wdata;
  logic                 cur_we;
  logic [CW-1:0]        best_wdata;

  // ---------------------------------------------------------------- decode
  logic [NW-1:0]  nc_ext, n;
  logic           pa_ok, pb_ok, swap_ok, load_ok, frozen_now, round_start;
  logic [CW-1:0]  pa_t, pb_t, ipos, walk_addr, b_city;
  logic [PCW-1:0] round_lim, pcount_inc;
  logic [47:0]    cool_prod;
  logic           iss_go, cp_go, done_fire;
  logic [AW-1:0]  dsum;
  logic [COST_W-1:0] acc_sat, chg;
  logic           lower, below_best;

  assign nc_ext = NW'(num_cities_q);
  assign n = (nc_ext < NW'(2)) ? NW'(2) :
             (nc_ext > NW'(MAX_CITIES)) ? NW'(MAX_CITIES) : nc_ext;
  assign pa_ok   = NW'(pa_q) < n;
  assign pb_ok   = NW'(pb_q) < n;
  assign swap_ok = (pa_q != 6'd0) && (pb_q != 6'd0) && (pa_q != pb_q) && pa_ok && pb_ok;
  assign load_ok = (NW'(pa_q) < NW'(MAX_CITIES)) && (NW'(pb_q) < NW'(MAX_CITIES));
  assign pa_t    = CW'(pa_q);
  assign pb_t    = CW'(pb_q);
  assign frozen_now  = temp_q <= {16'd0, freeze_q};
  assign round_start = pcount_q == '0;
  assign round_lim   = PCW'(ROUND_FACTOR * n);
  assign pcount_inc  = pcount_q + PCW'(1);
  assign cool_prod   = 48'(temp_q) * 48'(cool_q);

  // tour walk: position i of the swapped tour reads entry pb at pa and back
  assign ipos = CW'(iss_q);
  assign walk_addr = (swp_q && ipos == pa_t) ? pb_t :
                     (swp_q && ipos == pb_t) ? pa_t : ipos;
  assign iss_go = (state_q == ST_WALK) && (iss_q < n);
  assign b_city = a_vbit_q ? cur_rdata : a_addr_q;
  assign dist_raddr = close_q ? {prev_q, first_q} : {prev_q, b_city};

  assign dsum    = AW'(acc_q) + AW'(dist_rdata);
  assign acc_sat = (dsum > AW'(COST_MAX)) ? COST_MAX : dsum[COST_W-1:0];
  assign lower      = acc_q < cur_cost_q;
  assign below_best = acc_q < best_cost_q;
  assign chg        = acc_q - cur_cost_q;

  assign cp_go = (state_q == ST_COPY) && (cp_iss_q < NW'(MAX_CITIES));

  // restoring divider step
  logic [32:0] r2, rem_n;
  logic        ge;
  assign r2    = {rem_q[31:0], dd_q[53]};
  assign ge    = r2 >= {1'b0, temp_q};
  assign rem_n = ge ? (r2 - {1'b0, temp_q}) : r2;

  // series term: floor(y / i) by reciprocal and one correction
  logic [30:0] qd, qc, s_new;
  logic [34:0] qi, rr;
  assign qd    = yq_q[62:32];
  assign qi    = 35'(qd) * 35'(i_q);
  assign rr    = 35'(y_q) - qi;
  assign qc    = (rr >= 35'(i_q)) ? (qd + 31'd1) : qd;
  assign s_new = (qc >= Q30_ONE) ? 31'd0 : (Q30_ONE - qc);

  logic [61:0] pw, psum;
  logic [16:0] p_val;
  assign pw    = 62'(ek_q) * 62'(e1_q) + (62'd1 << 29);
  assign psum  = pprod_q + (62'd1 << 43);
  assign p_val = psum[60:44];

  assign done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (cmd_q)
          CMD_LOAD:    state_d = ST_DONE;
          CMD_RESET:   state_d = ST_WALK;
          CMD_FORCE:   state_d = swap_ok ? ST_WALK : ST_DONE;
          CMD_PROPOSE: state_d = (!swap_ok || (round_start && frozen_now)) ? ST_DONE : ST_WALK;
          CMD_READ:    state_d = pa_ok ? ST_RDB : ST_DONE;
          default:     state_d = ST_DONE;
        endcase
      end
      ST_WALK: begin
        if (d_vld_q && d_end_q) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        case (cmd_q)
          CMD_FORCE: state_d = ST_WR_A;
          CMD_PROPOSE: begin
            if (lower || chg == '0) state_d = ST_WR_A;
            else if (temp_q == '0)  state_d = ST_DONE;
            else                    state_d = ST_DIV;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_DIV: begin
        if (div_cnt_q == 6'd1) state_d = ST_XCHK;
      end
      ST_XCHK: begin
        state_d = (big_q || xq_q[19:16] >= EXP_K_LIMIT) ? ST_DONE : ST_SER_MUL;
      end
      ST_SER_MUL: state_d = ST_SER_DIV;
      ST_SER_DIV: state_d = ST_SER_FIX;
      ST_SER_FIX: begin
        if (i_q == 4'd1) state_d = phase_q ? ST_PMUL : ST_POW;
        else             state_d = ST_SER_MUL;
      end
      ST_POW: begin
        if (pow_cnt_q == '0) state_d = ST_SER_MUL;
      end
      ST_PMUL: state_d = ST_PFIN;
      ST_PFIN: state_d = ({1'b0, u_q} < p_val) ? ST_WR_A : ST_DONE;
      ST_WR_A: state_d = ST_WR_B;
      ST_WR_B: state_d = best_upd_q ? ST_COPY : ST_DONE;
      ST_COPY: begin
        if (!cp_go && !cp_vld_q) state_d = ST_DONE;
      end
      ST_RDB: state_d = ST_DONE;
      ST_DONE: begin
        if (done_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      num_cities_q <= NUM_CITIES_RST;
      init_temp_q  <= INIT_TEMP_RST;
      cool_q       <= COOL_RST;
      freeze_q     <= FREEZE_RST;
      cur_vld_q    <= '0;
      best_vld_q   <= '0;
      cur_cost_q   <= '0;
      best_cost_q  <= COST_MAX;
      temp_q       <= INIT_TEMP_RST;
      pcount_q     <= '0;
      a_vld_q      <= 1'b0;
      close_q      <= 1'b0;
      d_vld_q      <= 1'b0;
      d_end_q      <= 1'b0;
      cp_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_NUM_CITIES: num_cities_q <= cfg_data_i[6:0];
          CFG_INIT_TEMP:  init_temp_q  <= cfg_data_i;
          CFG_COOL_RATE:  cool_q       <= cfg_data_i[15:0];
          CFG_FREEZE:     freeze_q     <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      if (state_q == ST_DECODE) begin
        if (cmd_q == CMD_RESET) begin
          cur_vld_q  <= '0;
          best_vld_q <= '0;
          temp_q     <= init_temp_q;
          pcount_q   <= '0;
        end else if (cmd_q == CMD_PROPOSE && swap_ok && !(round_start && frozen_now)) begin
          if (round_start) temp_q <= cool_prod[47:16];
          pcount_q <= (pcount_inc >= round_lim) ? '0 : pcount_inc;
        end
      end

      if (state_q == ST_EVAL) begin
        case (cmd_q)
          CMD_RESET, CMD_FORCE: begin
            cur_cost_q  <= acc_q;
            best_cost_q <= acc_q;
          end
          CMD_PROPOSE: begin
            if (lower) begin
              cur_cost_q <= acc_q;
              if (below_best) best_cost_q <= acc_q;
            end
          end
          default: ;
        endcase
      end

      if (state_q == ST_PFIN && {1'b0, u_q} < p_val) cur_cost_q <= acc_q;
      if (state_q == ST_WR_A) cur_vld_q[pa_t] <= 1'b1;
      if (state_q == ST_WR_B) cur_vld_q[pb_t] <= 1'b1;
      if (cp_vld_q) best_vld_q[cp_addr_q] <= 1'b1;

      a_vld_q  <= iss_go;
      close_q  <= a_vld_q && a_last_q;
      d_vld_q  <= (a_vld_q && !a_first_q) || close_q;
      d_end_q  <= close_q;
      cp_vld_q <= cp_go;

      if (done_fire)        out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- datapath regs
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      cmd_q  <= cmd_i;
      pa_q   <= pos_a_i;
      pb_q   <= pos_b_i;
      dist_q <= distance_i;
      u_q    <= rand_u_i;
    end

    if (state_q == ST_DECODE) begin
      res_acc_q  <= 1'b0;
      res_city_q <= '0;
      best_upd_q <= 1'b0;
      iss_q      <= '0;
      acc_q      <= '0;
      swp_q      <= (cmd_q == CMD_FORCE) || (cmd_q == CMD_PROPOSE);
      rb_vbit_q  <= best_vld_q[pa_t];
      rb_addr_q  <= pa_t;
      case (cmd_q)
        CMD_LOAD:    res_status_q <= load_ok ? STAT_OK : STAT_INVALID;
        CMD_RESET:   res_status_q <= STAT_OK;
        CMD_FORCE:   res_status_q <= swap_ok ? STAT_OK : STAT_INVALID;
        CMD_PROPOSE: res_status_q <= !swap_ok ? STAT_INVALID :
                                     (round_start && frozen_now) ? STAT_FROZEN : STAT_OK;
        CMD_READ:    res_status_q <= pa_ok ? STAT_OK : STAT_INVALID;
        default:     res_status_q <= STAT_INVALID;
      endcase
    end

    if (iss_go) begin
      iss_q     <= iss_q + NW'(1);
      a_addr_q  <= walk_addr;
      a_vbit_q  <= cur_vld_q[walk_addr];
      a_first_q <= iss_q == '0;
      a_last_q  <= iss_q == (n - NW'(1));
      a_isa_q   <= ipos == pa_t;
      a_isb_q   <= ipos == pb_t;
    end
    if (a_vld_q) begin
      if (a_first_q) first_q <= b_city;
      prev_q <= b_city;
      if (a_isa_q) new_a_q <= b_city;
      if (a_isb_q) new_b_q <= b_city;
    end
    if (d_vld_q) acc_q <= acc_sat;

    if (state_q == ST_EVAL) begin
      if (cmd_q == CMD_FORCE) best_upd_q <= 1'b1;
      if (cmd_q == CMD_PROPOSE) begin
        if (lower) begin
          res_acc_q  <= 1'b1;
          best_upd_q <= below_best;
        end else if (chg == '0) begin
          res_acc_q <= 1'b1;
        end
      end
      rem_q     <= '0;
      dd_q      <= {chg, 32'd0};
      div_cnt_q <= DIV_STEPS;
      xq_q      <= '0;
      big_q     <= 1'b0;
    end

    if (state_q == ST_DIV) begin
      rem_q     <= rem_n;
      dd_q      <= {dd_q[52:0], 1'b0};
      xq_q      <= {xq_q[18:0], ge};
      big_q     <= big_q | xq_q[19];
      div_cnt_q <= div_cnt_q - 6'd1;
    end

    if (state_q == ST_XCHK) begin
      t_q     <= Q30_ONE;
      s_q     <= Q30_ONE;
      i_q     <= SERIES_TERMS;
      phase_q <= 1'b0;
    end
    if (state_q == ST_SER_MUL) prod_q <= 62'(t_q) * 62'(s_q);
    if (state_q == ST_SER_DIV) begin
      y_q  <= prod_q[60:30];
      yq_q <= 63'(prod_q[60:30]) * 63'(recip(i_q));
    end
    if (state_q == ST_SER_FIX) begin
      s_q <= s_new;
      i_q <= i_q - 4'd1;
      if (i_q == 4'd1) begin
        if (phase_q) begin
          ef_q <= s_new;
        end else begin
          e1_q      <= s_new;
          ek_q      <= Q30_ONE;
          pow_cnt_q <= xq_q[19:16];
        end
      end
    end
    if (state_q == ST_POW) begin
      if (pow_cnt_q == '0) begin
        t_q     <= {1'b0, xq_q[15:0], 14'd0};
        s_q     <= Q30_ONE;
        i_q     <= SERIES_TERMS;
        phase_q <= 1'b1;
      end else begin
        ek_q      <= pw[60:30];
        pow_cnt_q <= pow_cnt_q - 4'd1;
      end
    end
    if (state_q == ST_PMUL) pprod_q <= 62'(ef_q) * 62'(ek_q);
    if (state_q == ST_PFIN && {1'b0, u_q} < p_val) res_acc_q <= 1'b1;

    if (state_q == ST_RDB) res_city_q <= CITY_W'(rb_vbit_q ? best_rdata : rb_addr_q);

    if (state_q == ST_WR_B) cp_iss_q <= '0;
    if (cp_go) begin
      cp_iss_q  <= cp_iss_q + NW'(1);
      cp_addr_q <= CW'(cp_iss_q);
      cp_vbit_q <= cur_vld_q[CW'(cp_iss_q)];
    end

    if (done_fire) begin
      out_cur_q    <= cur_cost_q;
      out_best_q   <= best_cost_q;
      out_acc_q    <= res_acc_q;
      out_frz_q    <= frozen_now;
      out_city_q   <= res_city_q;
      out_status_q <= res_status_q;
    end
  end

  // ---------------------------------------------------------------- memories
  assign dist_we   = (state_q == ST_DECODE) && (cmd_q == CMD_LOAD) && load_ok;
  assign cur_raddr = (state_q == ST_COPY) ? CW'(cp_iss_q) : walk_addr;
  assign cur_we    = (state_q == ST_WR_A) || (state_q == ST_WR_B);
  assign cur_waddr = (state_q == ST_WR_A) ? pa_t : pb_t;
  assign cur_wdata = (state_q == ST_WR_A) ? new_a_q : new_b_q;
  assign best_wdata = cp_vbit_q ? cur_rdata : cp_addr_q;

  tsp_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (1 << DAW)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i ({pa_t, pb_t}),
    .wdata_i (DIST_BITS'(dist_q)),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  tsp_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_CITIES)
  ) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .raddr_i (cur_raddr),
    .rdata_o (cur_rdata)
  );

  tsp_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_CITIES)
  ) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (cp_vld_q),
    .waddr_i (cp_addr_q),
    .wdata_i (best_wdata),
    .raddr_i (pa_t),
    .rdata_o (best_rdata)
  );

  // ---------------------------------------------------------------- ports
  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = state_q == ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign current_cost_o = out_cur_q;
  assign best_cost_o    = out_best_q;
  assign accepted_o     = out_acc_q;
  assign frozen_o       = out_frz_q;
  assign best_city_o    = out_city_q;
  assign status_o       = out_status_q;

endmodule
